// ===== rtl/core/swrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrb_pkg
// Shared types and codes of the sliding window retransmit buffer.
// ----------------------------------------------------------------------------
package swrb_pkg;

   // Sequence numbers and window positions share this width; max_sequence is 8 bits.
   localparam int SEQ_BITS = 8;

   localparam logic [3:0] FUNC_PUSH        = 4'd0;
   localparam logic [3:0] FUNC_FIND        = 4'd1;
   localparam logic [3:0] FUNC_UPDATE_TS   = 4'd2;
   localparam logic [3:0] FUNC_POP_TS      = 4'd3;
   localparam logic [3:0] FUNC_PEEK_MIN_TS = 4'd4;
   localparam logic [3:0] FUNC_POP_MIN_TS  = 4'd5;
   localparam logic [3:0] FUNC_PEEK_MIN_SQ = 4'd6;
   localparam logic [3:0] FUNC_POP_MIN_SQ  = 4'd7;
   localparam logic [3:0] FUNC_SLIDE       = 4'd8;
   localparam logic [3:0] FUNC_SLIDE_TO    = 4'd9;
   localparam logic [3:0] FUNC_HAS         = 4'd10;
   localparam logic [3:0] FUNC_RESIZE      = 4'd11;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_REJECTED  = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic [1:0] CSR_MAX_SEQUENCE  = 2'd0;
   localparam logic [1:0] CSR_CAPACITY      = 2'd1;
   localparam logic [1:0] CSR_INITIAL_SIZE  = 2'd2;

   // Per-cycle command to every cell of the entry chain.
   typedef struct packed {
      logic push;      // every cell takes its newer neighbor, cell 0 the new entry
      logic pull;      // selected cells take their older neighbor
      logic write_ts;  // the addressed cell takes a new timestamp
   } swrb_cell_ctl_type;

endpackage

// ===== rtl/core/swrb_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrb_cell
// One entry of the store: sequence number, timestamp and tag, shifted
// toward older positions on push and toward newer positions on removal.
// ----------------------------------------------------------------------------
module swrb_cell #(
   parameter int SEQ_BITS  = 8,
   parameter int TIME_BITS = 32,
   parameter int TAG_BITS  = 16
) (
   input  logic                        clock,
   input  swrb_pkg::swrb_cell_ctl_type ctl,
   input  logic                        sel_from,   // cell at or after the removed one
   input  logic                        sel_at,     // cell addressed by the update
   input  logic [SEQ_BITS-1:0]         newer_seq,
   input  logic [TIME_BITS-1:0]        newer_ts,
   input  logic [TAG_BITS-1:0]         newer_tag,
   input  logic [SEQ_BITS-1:0]         older_seq,
   input  logic [TIME_BITS-1:0]        older_ts,
   input  logic [TAG_BITS-1:0]         older_tag,
   input  logic [TIME_BITS-1:0]        new_ts,
   output logic [SEQ_BITS-1:0]         seq_q,
   output logic [TIME_BITS-1:0]        ts_q,
   output logic [TAG_BITS-1:0]         tag_q
);

   logic [SEQ_BITS-1:0]  seq_ff, seq_in;
   logic [TIME_BITS-1:0] ts_ff, ts_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;

   always_comb begin
      seq_in = seq_ff;
      ts_in  = ts_ff;
      tag_in = tag_ff;
      if (ctl.push) begin
         seq_in = newer_seq;
         ts_in  = newer_ts;
         tag_in = newer_tag;
      end else if (ctl.pull && sel_from) begin
         seq_in = older_seq;
         ts_in  = older_ts;
         tag_in = older_tag;
      end else if (ctl.write_ts && sel_at) begin
         ts_in = new_ts;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      ts_ff  <= ts_in;
      tag_ff <= tag_in;
   end

   assign seq_q = seq_ff;
   assign ts_q  = ts_ff;
   assign tag_q = tag_ff;

endmodule

// ===== rtl/core/swrb_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrb_mod
// Restoring remainder unit: operand modulo (max_sequence + 1), one bit
// of the operand per cycle.
// ----------------------------------------------------------------------------
module swrb_mod #(
   parameter int VAL_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [VAL_BITS-1:0] operand,
   input  logic [7:0]          max_sequence,
   output logic                done,
   output logic [7:0]          result
);

   localparam int CNT_W = $clog2(VAL_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [VAL_BITS-1:0] val_ff, val_in;
   logic [7:0]          rem_ff, rem_in;
   logic [8:0]          trial;
   logic [8:0]          modulus;

   always_comb begin
      modulus = {1'b0, max_sequence} + 9'd1;
      trial   = {rem_ff, val_ff[VAL_BITS-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VAL_BITS);
         val_in  = operand;
         rem_in  = 8'd0;
      end else if (busy_ff) begin
         rem_in = (trial >= modulus) ? 8'(trial - modulus) : trial[7:0];
         val_in = val_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign result = rem_ff;

endmodule

// ===== rtl/core/sliding_window_retransmit_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_retransmit_buffer
// Selective-repeat window with a bounded store of buffered packets.
// ----------------------------------------------------------------------------
// One request is worked at a time. A request without a search passes
// through decode, a start of the bit-serial remainder unit that forms the
// window end, the run of that unit and the load of the response register;
// the next request is accepted in the following cycle. Find, update, pop by
// timestamp and the minimum operations first walk the entry chain one entry
// a cycle from newest to oldest, with an apply step after the walk when an
// entry is returned; slide adds a second remainder pass. The longest request
// is a minimum scan over 32 entries. A finished response sits in an output
// register, so the next request is taken while it waits.
// ----------------------------------------------------------------------------
module sliding_window_retransmit_buffer #(
   parameter int DEPTH     = 32,
   parameter int TIME_BITS = 32,
   parameter int TAG_BITS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   // func, seqnum, timestamp, new_timestamp, packet_tag, new_window_size,
   // new_position, zero padded
   input  logic [((4+2*swrb_pkg::SEQ_BITS+2*TIME_BITS+TAG_BITS+8+7)/8)*8-1:0] req_tdata,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   // status, found_tag, found_seqnum, found_timestamp, in_window, start position,
   // end position, window_size_now, occupancy, available, is_full, is_empty,
   // zero padded
   output logic [((TAG_BITS+swrb_pkg::SEQ_BITS+TIME_BITS+39+7)/8)*8-1:0] rsp_tdata,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int SEQ_BITS = swrb_pkg::SEQ_BITS;
   localparam int RSP_SUM  = TAG_BITS + SEQ_BITS + TIME_BITS + 39;
   localparam int RSP_W    = ((RSP_SUM + 7) / 8) * 8;
   localparam int O_SEQ    = 4;
   localparam int O_TS     = O_SEQ + SEQ_BITS;
   localparam int O_NTS    = O_TS + TIME_BITS;
   localparam int O_TAG    = O_NTS + TIME_BITS;
   localparam int O_NSIZE  = O_TAG + TAG_BITS;
   localparam int O_NPOS   = O_NSIZE + 8;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int VAL_BITS = ((SEQ_BITS > 9) ? SEQ_BITS : 9) + 1;
   localparam int MW       = ((SEQ_BITS > 8) ? SEQ_BITS : 8) + 1;
   localparam int KW       = (TIME_BITS > SEQ_BITS) ? TIME_BITS : SEQ_BITS;
   localparam logic [8:0] DEPTH_C = 9'(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_SLIDE_WAIT, ST_SCAN, ST_APPLY, ST_END_GO, ST_END_WAIT,
      ST_RESULT
   } state_type;

   state_type            state_ff, state_in;
   logic [3:0]           func_ff, func_in;
   logic [SEQ_BITS-1:0]  seq_ff, seq_in;
   logic [TIME_BITS-1:0] ts_ff, ts_in;
   logic [TIME_BITS-1:0] nts_ff, nts_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic [7:0]           nsize_ff, nsize_in;
   logic [SEQ_BITS-1:0]  npos_ff, npos_in;

   logic [7:0]           max_seq_ff, max_seq_in;
   logic [5:0]           cap_ff, cap_in;
   logic [SEQ_BITS-1:0]  pos_ff, pos_in;
   logic [5:0]           size_ff, size_in;
   logic [5:0]           count_ff, count_in;
   logic [7:0]           end_ff, end_in;

   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [KW-1:0]        best_key_ff, best_key_in;
   logic [1:0]           status_ff, status_in;
   logic [TAG_BITS-1:0]  f_tag_ff, f_tag_in;
   logic [SEQ_BITS-1:0]  f_seq_ff, f_seq_in;
   logic [TIME_BITS-1:0] f_ts_ff, f_ts_in;
   logic                 inwin_ff, inwin_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   swrb_pkg::swrb_cell_ctl_type cell_ctl;
   logic [SEQ_BITS-1:0]  cell_seq [DEPTH];
   logic [TIME_BITS-1:0] cell_ts  [DEPTH];
   logic [TAG_BITS-1:0]  cell_tag [DEPTH];

   logic [SEQ_BITS-1:0]  rd_seq;
   logic [TIME_BITS-1:0] rd_ts;
   logic [TAG_BITS-1:0]  rd_tag;
   logic [KW-1:0]        rd_key;

   logic                 mod_start, mod_done;
   logic [VAL_BITS-1:0]  mod_operand;
   logic [7:0]           mod_result;

   logic [8:0]           cap_eff9;
   logic [5:0]           cap_eff;
   logic                 full_now;
   logic                 last_entry;
   logic                 min_op, find_op;
   logic                 is_hit;
   logic [MW-1:0]        s_pos, s_end, s_q;
   logic [5:0]           avail;

   // Entry chain.
   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      logic [SEQ_BITS-1:0]  newer_seq, older_seq;
      logic [TIME_BITS-1:0] newer_ts, older_ts;
      logic [TAG_BITS-1:0]  newer_tag, older_tag;
      if (j == 0) begin : g_head
         assign newer_seq = seq_ff;
         assign newer_ts  = ts_ff;
         assign newer_tag = tag_ff;
      end else begin : g_body
         assign newer_seq = cell_seq[j-1];
         assign newer_ts  = cell_ts[j-1];
         assign newer_tag = cell_tag[j-1];
      end
      if (j == DEPTH - 1) begin : g_tail
         assign older_seq = cell_seq[j];
         assign older_ts  = cell_ts[j];
         assign older_tag = cell_tag[j];
      end else begin : g_link
         assign older_seq = cell_seq[j+1];
         assign older_ts  = cell_ts[j+1];
         assign older_tag = cell_tag[j+1];
      end
      swrb_cell #(
         .SEQ_BITS  (SEQ_BITS),
         .TIME_BITS (TIME_BITS),
         .TAG_BITS  (TAG_BITS)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .sel_from  (9'(j) >= 9'(best_idx_ff)),
         .sel_at    (9'(j) == 9'(best_idx_ff)),
         .newer_seq (newer_seq),
         .newer_ts  (newer_ts),
         .newer_tag (newer_tag),
         .older_seq (older_seq),
         .older_ts  (older_ts),
         .older_tag (older_tag),
         .new_ts    (nts_ff),
         .seq_q     (cell_seq[j]),
         .ts_q      (cell_ts[j]),
         .tag_q     (cell_tag[j])
      );
   end

   swrb_mod #(
      .VAL_BITS (VAL_BITS)
   ) u_mod (
      .clock        (clock),
      .reset        (reset),
      .start        (mod_start),
      .operand      (mod_operand),
      .max_sequence (max_seq_ff),
      .done         (mod_done),
      .result       (mod_result)
   );

   assign rd_seq = cell_seq[idx_ff];
   assign rd_ts  = cell_ts[idx_ff];
   assign rd_tag = cell_tag[idx_ff];

   always_comb begin
      cap_eff9 = ({3'd0, cap_ff} < DEPTH_C) ? {3'd0, cap_ff} : DEPTH_C;
      cap_eff  = cap_eff9[5:0];
      full_now = (count_ff >= cap_eff) || (count_ff >= size_ff);
      avail    = (size_ff < count_ff) ? 6'd0 : (size_ff - count_ff);
      min_op   = (func_ff == swrb_pkg::FUNC_PEEK_MIN_TS) ||
                 (func_ff == swrb_pkg::FUNC_POP_MIN_TS) ||
                 (func_ff == swrb_pkg::FUNC_PEEK_MIN_SQ) ||
                 (func_ff == swrb_pkg::FUNC_POP_MIN_SQ);
      find_op  = (func_ff == swrb_pkg::FUNC_FIND) ||
                 (func_ff == swrb_pkg::FUNC_UPDATE_TS) ||
                 (func_ff == swrb_pkg::FUNC_POP_TS);
      rd_key   = ((func_ff == swrb_pkg::FUNC_PEEK_MIN_TS) ||
                  (func_ff == swrb_pkg::FUNC_POP_MIN_TS)) ? KW'(rd_ts) : KW'(rd_seq);
      is_hit   = (func_ff == swrb_pkg::FUNC_FIND) ? (rd_seq == seq_ff) : (rd_ts == ts_ff);
      last_entry = (9'(idx_ff) + 9'd1) >= {3'd0, count_ff};
      mod_start   = 1'b0;
      mod_operand = VAL_BITS'(pos_ff) + VAL_BITS'(size_ff) + VAL_BITS'(max_seq_ff);
      if (state_ff == ST_DECODE && func_ff == swrb_pkg::FUNC_SLIDE) begin
         mod_start   = 1'b1;
         mod_operand = VAL_BITS'(pos_ff) + VAL_BITS'(1);
      end else if (state_ff == ST_END_GO) begin
         mod_start = 1'b1;
      end
      s_pos = MW'(pos_ff);
      s_end = MW'(mod_result);
      s_q   = MW'(seq_ff);
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      seq_in       = seq_ff;
      ts_in        = ts_ff;
      nts_in       = nts_ff;
      tag_in       = tag_ff;
      nsize_in     = nsize_ff;
      npos_in      = npos_ff;
      max_seq_in   = max_seq_ff;
      cap_in       = cap_ff;
      pos_in       = pos_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      end_in       = end_ff;
      idx_in       = idx_ff;
      best_idx_in  = best_idx_ff;
      best_key_in  = best_key_ff;
      status_in    = status_ff;
      f_tag_in     = f_tag_ff;
      f_seq_in     = f_seq_ff;
      f_ts_in      = f_ts_ff;
      inwin_in     = inwin_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cell_ctl     = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            swrb_pkg::CSR_MAX_SEQUENCE: max_seq_in = csr_data;
            swrb_pkg::CSR_CAPACITY:     cap_in = csr_data[5:0];
            swrb_pkg::CSR_INITIAL_SIZE: begin
               size_in = (csr_data[5:0] < cap_eff) ? csr_data[5:0] : cap_eff;
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tdata[3:0];
               seq_in   = req_tdata[O_SEQ +: SEQ_BITS];
               ts_in    = req_tdata[O_TS +: TIME_BITS];
               nts_in   = req_tdata[O_NTS +: TIME_BITS];
               tag_in   = req_tdata[O_TAG +: TAG_BITS];
               nsize_in = req_tdata[O_NSIZE +: 8];
               npos_in  = req_tdata[O_NPOS +: SEQ_BITS];
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            status_in = swrb_pkg::STATUS_OK;
            f_tag_in  = '0;
            f_seq_in  = '0;
            f_ts_in   = '0;
            inwin_in  = 1'b0;
            idx_in    = '0;
            state_in  = ST_END_GO;
            if (func_ff == swrb_pkg::FUNC_PUSH) begin
               if (full_now) begin
                  status_in = swrb_pkg::STATUS_REJECTED;
               end else begin
                  cell_ctl.push = 1'b1;
                  count_in      = count_ff + 6'd1;
               end
            end else if (find_op || min_op) begin
               if (count_ff == 6'd0) begin
                  status_in = swrb_pkg::STATUS_NOT_FOUND;
               end else begin
                  state_in = ST_SCAN;
               end
            end else if (func_ff == swrb_pkg::FUNC_SLIDE) begin
               state_in = ST_SLIDE_WAIT;
            end else if (func_ff == swrb_pkg::FUNC_SLIDE_TO) begin
               if (MW'(npos_ff) > MW'(max_seq_ff)) begin
                  status_in = swrb_pkg::STATUS_REJECTED;
               end else begin
                  pos_in = npos_ff;
               end
            end else if (func_ff == swrb_pkg::FUNC_HAS) begin
               status_in = swrb_pkg::STATUS_OK;
            end else if (func_ff == swrb_pkg::FUNC_RESIZE) begin
               if ({1'b0, nsize_ff} > cap_eff9) begin
                  status_in = swrb_pkg::STATUS_REJECTED;
               end else begin
                  size_in = nsize_ff[5:0];
               end
            end else begin
               status_in = swrb_pkg::STATUS_REJECTED;
            end
         end
         ST_SLIDE_WAIT: begin
            if (mod_done) begin
               pos_in   = SEQ_BITS'(mod_result);
               state_in = ST_END_GO;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + IDX_W'(1);
            if (find_op) begin
               if (is_hit) begin
                  best_idx_in = idx_ff;
                  f_tag_in    = rd_tag;
                  f_seq_in    = rd_seq;
                  f_ts_in     = rd_ts;
                  state_in    = ST_APPLY;
               end else if (last_entry) begin
                  status_in = swrb_pkg::STATUS_NOT_FOUND;
                  state_in  = ST_END_GO;
               end
            end else begin
               // Strict compare, newest first, so ties keep the newer entry.
               if (idx_ff == '0 || rd_key < best_key_ff) begin
                  best_idx_in = idx_ff;
                  best_key_in = rd_key;
                  f_tag_in    = rd_tag;
                  f_seq_in    = rd_seq;
                  f_ts_in     = rd_ts;
               end
               if (last_entry) begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            state_in = ST_END_GO;
            if (func_ff == swrb_pkg::FUNC_UPDATE_TS) begin
               cell_ctl.write_ts = 1'b1;
               f_ts_in           = nts_ff;
            end else if (func_ff == swrb_pkg::FUNC_POP_TS ||
                         func_ff == swrb_pkg::FUNC_POP_MIN_TS ||
                         func_ff == swrb_pkg::FUNC_POP_MIN_SQ) begin
               cell_ctl.pull = 1'b1;
               count_in      = count_ff - 6'd1;
            end
         end
         ST_END_GO: begin
            state_in = ST_END_WAIT;
         end
         ST_END_WAIT: begin
            if (mod_done) begin
               end_in = mod_result;
               if (func_ff == swrb_pkg::FUNC_HAS && size_ff != 6'd0) begin
                  if (s_pos > s_end) begin
                     inwin_in = (s_pos <= s_q) || (s_q <= s_end);
                  end else begin
                     inwin_in = (s_pos <= s_q) && (s_q <= s_end);
                  end
               end
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({count_ff == 6'd0, full_now || (count_ff > cap_eff),
                                      avail, count_ff, size_ff, end_ff, pos_ff,
                                      inwin_ff, f_ts_ff, f_seq_ff, f_tag_ff, status_ff});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_seq_ff   <= 8'd255;
         cap_ff       <= 6'd32;
         pos_ff       <= '0;
         size_ff      <= (DEPTH_C >= 9'd1) ? 6'd1 : 6'd0;
         count_ff     <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_seq_ff   <= max_seq_in;
         cap_ff       <= cap_in;
         pos_ff       <= pos_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      seq_ff      <= seq_in;
      ts_ff       <= ts_in;
      nts_ff      <= nts_in;
      tag_ff      <= tag_in;
      nsize_ff    <= nsize_in;
      npos_ff     <= npos_in;
      end_ff      <= end_in;
      idx_ff      <= idx_in;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
      status_ff   <= status_in;
      f_tag_ff    <= f_tag_in;
      f_seq_ff    <= f_seq_in;
      f_ts_ff     <= f_ts_in;
      inwin_ff    <= inwin_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule
